// ----- hdl/sme_pkg.sv -----
// shared types, opcodes and constants for the stack machine executor
package sme_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int CODE_DEPTH  = 4096;
    localparam int SAW         = $clog2(STACK_DEPTH);
    localparam int SPW         = $clog2(STACK_DEPTH + 1);
    localparam int PCW         = $clog2(CODE_DEPTH);

    typedef enum logic [3:0] {
        OP_LIT = 4'd0,  OP_LOD = 4'd1,  OP_STO = 4'd2,  OP_CAL = 4'd3,
        OP_INT = 4'd4,  OP_JMP = 4'd5,  OP_JPC = 4'd6,  OP_ADD = 4'd7,
        OP_SUB = 4'd8,  OP_MUL = 4'd9,  OP_DIV = 4'd10, OP_RED = 4'd11,
        OP_WRT = 4'd12, OP_RET = 4'd13
    } opcode_t;

    localparam logic [1:0] FAULT_NONE  = 2'd0;
    localparam logic [1:0] FAULT_DIV0  = 2'd1;
    localparam logic [1:0] FAULT_RANGE = 2'd2;

    // request to the divider and its answer
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;

endpackage

// ----- hdl/sme_divider.sv -----
// radix-2 restoring divider, signed, truncating toward zero
module sme_divider
    import sme_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [31:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dsr_reg, dsr_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        neg_reg, neg_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        trial     = {rem_reg[31:0], quo_reg[31]} - {1'b0, dsr_reg};
        if (req.start)
        begin
            // load magnitudes
            quo_next  = req.dividend[31] ? (32'd0 - req.dividend) : req.dividend;
            dsr_next  = req.divisor[31] ? (32'd0 - req.divisor) : req.divisor;
            rem_next  = 33'd0;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
            neg_next  = req.dividend[31] ^ req.divisor[31];
        end
        else if (busy_reg)
        begin
            // one quotient bit a cycle
            if (!trial[32])
            begin
                rem_next = trial;
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[31:0], quo_reg[31]};
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? (32'd0 - quo_reg) : quo_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg) else $error("divider done while busy");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> busy_reg) else $error("divider failed to start");
    a_count_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != 6'd0) else $error("divider count ran out");

endmodule

// ----- hdl/stack_machine_executor.sv -----
// top level: sequencer, stack store and shared alu of the stack machine executor
//
// Input channel (valid/ready: func, operand, read_value) carries one instruction
// per transfer; output channel (valid/ready) returns one result per instruction:
// next_pc, write_valid, write_value, halted and fault.
// After reset a clearing pass writes zero to every stack word, one word a
// cycle; ready stays low meanwhile.
// Each instruction is worked by a sequencer around a single-port stack store
// with registered read data and one shared add/multiply unit. States from the
// input transfer: RD1 for all; then LIT, INT, JMP, RED and unknown opcodes: FIN;
//   JPC, WRT: EXEC, FIN; LOD, STO: EXEC, WR2, FIN; CAL: WR1, WR2, FIN;
//   RET: EXEC, RD2, FIN; ADD, SUB, MUL: EXEC, RD2, WR2, FIN; DIV by zero: EXEC, RD2, FIN;
//   DIV: EXEC, RD2, DIV, WR2, FIN, with the radix-2 divider (one bit a cycle).
// The store port is the limit: each state makes at most one access.
// FIN raises valid_out in OUT; after the result transfer the sequencer returns
// to IDLE, where the next input transfer is taken.
// The result sits in an output register; while the receiver stalls it holds,
// and no new instruction is taken until the result transfer completes.
module stack_machine_executor
    import sme_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid_in,
    output logic        ready_in,
    input  logic [3:0]  func,
    input  logic signed [31:0] operand,
    input  logic signed [31:0] read_value,
    output logic        valid_out,
    input  logic        ready_out,
    output logic [11:0] next_pc,
    output logic        write_valid,
    output logic signed [31:0] write_value,
    output logic        halted,
    output logic [1:0]  fault
);

    typedef enum logic [9:0] {
        S_CLEAR = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_RD1   = 10'b0000000100,
        S_RD2   = 10'b0000001000,
        S_EXEC  = 10'b0000010000,
        S_WR1   = 10'b0000100000,
        S_WR2   = 10'b0001000000,
        S_DIV   = 10'b0010000000,
        S_FIN   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] mem [STACK_DEPTH];
    logic [31:0] rdata_reg;
    logic        mem_we;
    logic [SAW-1:0] mem_addr;
    logic [31:0] mem_wdata;

    logic [3:0]  func_reg;
    logic [31:0] opnd_reg, rdv_reg;
    logic [PCW-1:0] pc_reg, pc_next;
    logic [SPW-1:0] sp_reg, sp_next, fb_reg, fb_next;
    logic [31:0] a_reg, a_next, b_reg, b_next;
    logic [1:0]  flt_reg, flt_next;
    logic [SAW:0] clr_reg, clr_next;
    logic        wv_reg, wv_next;
    logic [31:0] wval_reg, wval_next;
    logic        vout_reg, vout_next;

    div_req_t dreq;
    div_rsp_t drsp;

    sme_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    // signed address arithmetic, 34 bits covers base plus any operand
    logic signed [33:0] fb_off, fb_off1, fb_off2, sp_m1, int_sum;
    logic fb_off_ok, sp_m1_ok;
    logic signed [33:0] saved_fb;
    logic [31:0] alu_out;

    assign fb_off   = $signed({23'd0, fb_reg}) + $signed({{2{opnd_reg[31]}}, opnd_reg});
    assign fb_off1  = $signed({23'd0, fb_reg}) + 34'sd1;
    assign fb_off2  = $signed({23'd0, fb_reg}) + 34'sd2;
    assign sp_m1    = $signed({23'd0, sp_reg}) - 34'sd1;
    assign int_sum  = $signed({23'd0, sp_reg}) + $signed({{2{opnd_reg[31]}}, opnd_reg});
    assign saved_fb = $signed({{2{rdata_reg[31]}}, rdata_reg});

    function automatic logic in_range(input logic signed [33:0] a);
        in_range = (a >= 34'sd0) && (a < 34'(STACK_DEPTH));
    endfunction

    assign fb_off_ok = in_range(fb_off);
    assign sp_m1_ok  = in_range(sp_m1);

    // shared arithmetic unit
    always_comb
    begin
        case (func_reg)
            OP_ADD:  alu_out = a_reg + b_reg;
            OP_SUB:  alu_out = a_reg - b_reg;
            OP_MUL:  alu_out = a_reg * b_reg;
            default: alu_out = a_reg + 32'd1;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        sp_next    = sp_reg;
        fb_next    = fb_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        flt_next   = flt_reg;
        clr_next   = clr_reg;
        wv_next    = wv_reg;
        wval_next  = wval_reg;
        vout_next  = vout_reg;
        mem_we     = 1'b0;
        mem_addr   = '0;
        mem_wdata  = 32'd0;
        dreq       = '0;
        case (state_reg)
            S_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_addr = clr_reg[SAW-1:0];
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (SAW+1)'(STACK_DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (valid_in)
                begin
                    pc_next    = pc_reg + 1'b1;
                    flt_next   = FAULT_NONE;
                    wv_next    = 1'b0;
                    wval_next  = 32'd0;
                    state_next = S_RD1;
                end
            end
            S_RD1:
            begin
                // first action: issue a read or act directly
                state_next = S_FIN;
                case (func_reg)
                    OP_LIT, OP_RED:
                    begin
                        if (sp_reg == SPW'(STACK_DEPTH))
                            flt_next = FAULT_RANGE;
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_addr  = sp_reg[SAW-1:0];
                            mem_wdata = (func_reg == OP_LIT) ? opnd_reg : rdv_reg;
                            sp_next   = sp_reg + 1'b1;
                        end
                    end
                    OP_LOD:
                    begin
                        mem_addr   = fb_off[SAW-1:0];
                        state_next = S_EXEC;
                    end
                    OP_STO, OP_JPC, OP_WRT, OP_ADD, OP_SUB, OP_MUL, OP_DIV:
                    begin
                        mem_addr   = sp_m1[SAW-1:0];
                        state_next = S_EXEC;
                    end
                    OP_CAL:
                    begin
                        a_next     = {{(32-PCW){1'b0}}, pc_reg};
                        state_next = S_WR1;
                        if (sp_reg == SPW'(STACK_DEPTH))
                            flt_next = FAULT_RANGE;
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_addr  = sp_reg[SAW-1:0];
                            mem_wdata = {{(32-SPW){1'b0}}, fb_reg};
                        end
                    end
                    OP_INT:
                    begin
                        if (int_sum < 34'sd0)
                        begin
                            sp_next  = '0;
                            flt_next = FAULT_RANGE;
                        end
                        else if (int_sum > 34'(STACK_DEPTH))
                        begin
                            sp_next  = SPW'(STACK_DEPTH);
                            flt_next = FAULT_RANGE;
                        end
                        else
                            sp_next = int_sum[SPW-1:0];
                    end
                    OP_JMP: pc_next = opnd_reg[PCW-1:0];
                    OP_RET:
                    begin
                        sp_next    = fb_reg;
                        mem_addr   = fb_off2[SAW-1:0];
                        state_next = S_EXEC;
                    end
                    default: ;
                endcase
            end
            S_EXEC:
            begin
                // registered read data is available
                state_next = S_FIN;
                case (func_reg)
                    OP_LOD:
                    begin
                        a_next = fb_off_ok ? rdata_reg : 32'd0;
                        if (!fb_off_ok) flt_next = FAULT_RANGE;
                        state_next = S_WR2;
                    end
                    OP_STO:
                    begin
                        if (sp_reg == '0)
                        begin
                            flt_next = FAULT_RANGE;
                            a_next   = 32'd0;
                        end
                        else
                        begin
                            a_next  = rdata_reg;
                            sp_next = sp_reg - 1'b1;
                        end
                        state_next = S_WR2;
                    end
                    OP_JPC:
                    begin
                        if (sp_reg == '0)
                        begin
                            flt_next = FAULT_RANGE;
                            pc_next  = opnd_reg[PCW-1:0];
                        end
                        else
                        begin
                            sp_next = sp_reg - 1'b1;
                            if (rdata_reg == 32'd0) pc_next = opnd_reg[PCW-1:0];
                        end
                    end
                    OP_WRT:
                    begin
                        wv_next = 1'b1;
                        if (sp_reg == '0)
                            flt_next = FAULT_RANGE;
                        else
                        begin
                            wval_next = rdata_reg;
                            sp_next   = sp_reg - 1'b1;
                        end
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV:
                    begin
                        // pop b, then read a below it
                        if (sp_reg == '0)
                        begin
                            flt_next = FAULT_RANGE;
                            b_next   = 32'd0;
                        end
                        else
                        begin
                            b_next  = rdata_reg;
                            sp_next = sp_reg - 1'b1;
                        end
                        mem_addr   = (sp_reg == '0) ? '0 : SAW'(sp_reg - 2'd2);
                        state_next = S_RD2;
                    end
                    OP_RET:
                    begin
                        pc_next    = rdata_reg[PCW-1:0];
                        mem_addr   = fb_off1[SAW-1:0];
                        state_next = S_RD2;
                    end
                    default: ;
                endcase
            end
            S_RD2:
            begin
                state_next = S_FIN;
                if (func_reg == OP_RET)
                begin
                    if (!in_range(fb_off2) || !in_range(fb_off1))
                        flt_next = FAULT_RANGE;
                    if (!in_range(fb_off2)) pc_next = '0;
                    if (!in_range(fb_off1) || saved_fb < 34'sd0 ||
                        saved_fb > 34'(STACK_DEPTH))
                    begin
                        fb_next  = '0;
                        flt_next = FAULT_RANGE;
                    end
                    else
                        fb_next = saved_fb[SPW-1:0];
                end
                else
                begin
                    // a at sp-1 after the pop
                    a_next = sp_m1_ok ? rdata_reg : 32'd0;
                    if (!sp_m1_ok) flt_next = FAULT_RANGE;
                    if (func_reg == OP_DIV)
                    begin
                        if (b_reg == 32'd0)
                        begin
                            if (sp_m1_ok && flt_reg == FAULT_NONE)
                                flt_next = FAULT_DIV0;
                        end
                        else
                        begin
                            dreq.start    = 1'b1;
                            dreq.dividend = sp_m1_ok ? rdata_reg : 32'd0;
                            dreq.divisor  = b_reg;
                            state_next    = S_DIV;
                        end
                    end
                    else
                        state_next = S_WR2;
                end
            end
            S_DIV:
            begin
                if (drsp.done)
                begin
                    a_next     = drsp.quotient;
                    state_next = S_WR2;
                end
            end
            S_WR1:
            begin
                // remaining CAL frame words
                if (sp_reg > SPW'(STACK_DEPTH - 2))
                    flt_next = FAULT_RANGE;
                else
                begin
                    mem_we    = 1'b1;
                    mem_addr  = SAW'(sp_reg + 1'b1);
                    mem_wdata = {{(32-SPW){1'b0}}, fb_reg};
                end
                b_next     = 32'd1;
                state_next = S_WR2;
            end
            S_WR2:
            begin
                state_next = S_FIN;
                case (func_reg)
                    OP_CAL:
                    begin
                        if (sp_reg > SPW'(STACK_DEPTH - 3))
                            flt_next = FAULT_RANGE;
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_addr  = SAW'(sp_reg + 2'd2);
                            mem_wdata = a_reg;
                        end
                        fb_next = sp_reg;
                        pc_next = opnd_reg[PCW-1:0];
                    end
                    OP_LOD:
                    begin
                        if (sp_reg == SPW'(STACK_DEPTH))
                            flt_next = FAULT_RANGE;
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_addr  = sp_reg[SAW-1:0];
                            mem_wdata = a_reg;
                            sp_next   = sp_reg + 1'b1;
                        end
                    end
                    OP_STO:
                    begin
                        if (!fb_off_ok)
                            flt_next = FAULT_RANGE;
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_addr  = fb_off[SAW-1:0];
                            mem_wdata = a_reg;
                        end
                    end
                    default:
                    begin
                        // arithmetic write-back at sp-1
                        if (sp_m1_ok)
                        begin
                            mem_we    = 1'b1;
                            mem_addr  = sp_m1[SAW-1:0];
                            mem_wdata = (func_reg == OP_DIV) ? a_reg : alu_out;
                        end
                    end
                endcase
            end
            S_FIN:
            begin
                vout_next  = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (ready_out)
                begin
                    vout_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // stack store, single port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        rdata_reg <= mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            pc_reg    <= '0;
            sp_reg    <= '0;
            fb_reg    <= '0;
            clr_reg   <= '0;
            vout_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            sp_reg    <= sp_next;
            fb_reg    <= fb_next;
            clr_reg   <= clr_next;
            vout_reg  <= vout_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        flt_reg  <= flt_next;
        wv_reg   <= wv_next;
        wval_reg <= wval_next;
        if (state_reg == S_IDLE && valid_in)
        begin
            func_reg <= func;
            opnd_reg <= operand;
            rdv_reg  <= read_value;
        end
    end

    assign ready_in    = (state_reg == S_IDLE);
    assign valid_out   = vout_reg;
    assign next_pc     = 12'(pc_reg);
    assign halted      = (pc_reg == '0);
    assign write_valid = wv_reg;
    assign write_value = wval_reg;
    assign fault       = flt_reg;

    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SPW'(STACK_DEPTH)) else $error("stack pointer out of range");
    a_fb_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fb_reg <= SPW'(STACK_DEPTH)) else $error("frame base out of range");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        valid_out |-> !ready_in) else $error("input taken while result pending");
    a_pc_step: assert property (@(posedge clk) disable iff (!rst_n)
        (ready_in && valid_in) |=> pc_reg == $past(pc_reg) + 1'b1)
        else $error("program counter did not advance");

endmodule

// ----- tb/testbench.sv -----
// testbench for the stack machine executor: random and directed instruction streams
module testbench
    import sme_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // expected result of one instruction
    typedef struct {
        logic [11:0] pc;
        logic        wv;
        logic [31:0] wval;
        logic        halt;
        logic [1:0]  flt;
    } step_result_t;

    // scoreboard: behavioural copy of the machine and the queue of pending results
    class step_scoreboard;
        logic [31:0]  mem [STACK_DEPTH];
        int unsigned  pc;
        int unsigned  fb;
        int unsigned  sp;
        logic [1:0]   flt;
        step_result_t pending[$];
        int           errors;

        function new();
            for (int i = 0; i < STACK_DEPTH; i++) mem[i] = '0;
            pc = 0; fb = 0; sp = 0; errors = 0;
        endfunction

        function logic [31:0] rd(longint a);
            if (a < 0 || a >= STACK_DEPTH)
            begin
                flt = FAULT_RANGE;
                return '0;
            end
            return mem[a];
        endfunction

        function void wr(longint a, logic [31:0] v);
            if (a < 0 || a >= STACK_DEPTH) flt = FAULT_RANGE;
            else mem[a] = v;
        endfunction

        function void push(logic [31:0] v);
            wr(sp, v);
            if (sp < STACK_DEPTH) sp++;
        endfunction

        function logic [31:0] pop();
            if (sp == 0)
            begin
                flt = FAULT_RANGE;
                return '0;
            end
            sp--;
            return mem[sp];
        endfunction

        // note an accepted instruction and work out its result
        function void note_instruction(logic [3:0] f, logic [31:0] op, logic [31:0] rv);
            logic [31:0] a;
            logic [31:0] b;
            longint      n;
            longint      top;
            logic        dz;
            step_result_t r;
            dz = 0;
            flt = FAULT_NONE;
            r.wv = 0;
            r.wval = '0;
            pc = (pc + 1) % CODE_DEPTH;
            case (f)
                OP_LIT: push(op);
                OP_LOD: push(rd(longint'(fb) + longint'($signed(op))));
                OP_STO:
                begin
                    a = pop();
                    wr(longint'(fb) + longint'($signed(op)), a);
                end
                OP_CAL:
                begin
                    wr(sp, fb);
                    wr(longint'(sp) + 1, fb);
                    wr(longint'(sp) + 2, pc);
                    fb = sp;
                    pc = op % CODE_DEPTH;
                end
                OP_INT:
                begin
                    n = longint'(sp) + longint'($signed(op));
                    if (n < 0)
                    begin
                        n = 0;
                        flt = FAULT_RANGE;
                    end
                    if (n > STACK_DEPTH)
                    begin
                        n = STACK_DEPTH;
                        flt = FAULT_RANGE;
                    end
                    sp = n;
                end
                OP_JMP: pc = op % CODE_DEPTH;
                OP_JPC: if (pop() == 0) pc = op % CODE_DEPTH;
                OP_ADD, OP_SUB, OP_MUL, OP_DIV:
                begin
                    b = pop();
                    top = longint'(sp) - 1;
                    a = rd(top);
                    if (f == OP_DIV && b == 0) dz = 1;
                    else
                    begin
                        case (f)
                            OP_ADD: a = a + b;
                            OP_SUB: a = a - b;
                            OP_MUL: a = a * b;
                            default:
                            begin
                                // most negative over minus one stays as it is
                                if (!(a == 32'h8000_0000 && b == '1))
                                    a = $signed(a) / $signed(b);
                            end
                        endcase
                        wr(top, a);
                    end
                end
                OP_RED: push(rv);
                OP_WRT:
                begin
                    r.wv = 1;
                    r.wval = pop();
                end
                OP_RET:
                begin
                    sp = fb;
                    a = rd(longint'(fb) + 2);
                    n = longint'($signed(rd(longint'(fb) + 1)));
                    pc = a % CODE_DEPTH;
                    if (n < 0 || n > STACK_DEPTH)
                    begin
                        fb = 0;
                        flt = FAULT_RANGE;
                    end
                    else fb = n;
                end
                default: ;
            endcase
            if (flt == FAULT_NONE && dz) flt = FAULT_DIV0;
            r.pc = 12'(pc);
            r.halt = (pc == 0);
            r.flt = flt;
            pending.push_back(r);
        endfunction

        // compare one result transfer with the oldest expectation
        function void check_result(logic [11:0] p, logic wv, logic [31:0] wval,
                                   logic h, logic [1:0] f);
            step_result_t e;
            if (pending.size() == 0)
            begin
                $error("result with nothing expected: next_pc %0d", p);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (p !== e.pc)
            begin
                $error("next_pc expected %0d actual %0d", e.pc, p);
                errors++;
            end
            if (wv !== e.wv)
            begin
                $error("write_valid expected %0d actual %0d", e.wv, wv);
                errors++;
            end
            if (wval !== e.wval)
            begin
                $error("write_value expected %0h actual %0h", e.wval, wval);
                errors++;
            end
            if (h !== e.halt)
            begin
                $error("halted expected %0d actual %0d", e.halt, h);
                errors++;
            end
            if (f !== e.flt)
            begin
                $error("fault expected %0d actual %0d", e.flt, f);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        valid_in;
    logic        ready_in;
    logic [3:0]  func;
    logic signed [31:0] operand;
    logic signed [31:0] read_value;
    logic        valid_out;
    logic        ready_out;
    logic [11:0] next_pc;
    logic        write_valid;
    logic signed [31:0] write_value;
    logic        halted;
    logic [1:0]  fault;

    step_scoreboard sb;
    logic calm;           // no idling in the last part
    logic hold_off;       // long receiver stall
    longint cycles;

    stack_machine_executor uut (.*);

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // instruction transfer: offer, wait for acceptance, then maybe idle
    task automatic send(logic [3:0] f, logic [31:0] op, logic [31:0] rv);
        valid_in   <= 1;
        func       <= f;
        operand    <= op;
        read_value <= rv;
        @(posedge clk);
        while (!ready_in) @(posedge clk);
        sb.note_instruction(f, op, rv);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            valid_in <= 0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '1;
            3: return $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    // mostly well-formed instructions with small offsets, some noise
    task automatic send_random();
        logic [3:0]  f;
        logic [31:0] op;
        int unsigned d;
        d = sb.sp;
        f = $urandom_range(0, 15);
        case (f)
            OP_LOD, OP_STO: op = ($urandom_range(0, 9) == 0) ? rand_word()
                                 : $urandom_range(0, 8) - 2;
            OP_INT: op = ($urandom_range(0, 9) == 0) ? rand_word()
                         : (d > 40 ? -$urandom_range(0, 8) : $urandom_range(0, 6));
            OP_JMP, OP_JPC, OP_CAL: op = ($urandom_range(0, 3) == 0) ? 0 : rand_word();
            default: op = rand_word();
        endcase
        // keep the stack shallow by preferring pops when it grows
        if (d > 60 && f inside {OP_LIT, OP_LOD, OP_RED, OP_CAL}) f = OP_WRT;
        send(f, op, rand_word());
    endtask

    // result side: random stalls plus one long hold-off
    initial
    begin
        ready_out <= 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off) ready_out <= 0;
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                ready_out <= 0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                ready_out <= 1;
            end
            else ready_out <= 1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && valid_out && ready_out)
            sb.check_result(next_pc, write_valid, write_value, halted, fault);
    end

    // long hold-off counted in its own process
    initial
    begin
        hold_off = 0;
        @(posedge rst_n);
        repeat (3000) @(posedge clk);
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
    end

    // watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 400000)
            begin
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        sb = new();
        calm = 0;
        rst_n <= 0;
        valid_in <= 0;
        func <= '0;
        operand <= '0;
        read_value <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: extremes, every opcode and the special cases
        send(OP_WRT, 0, 0);                  // pop on empty stack
        send(OP_LIT, 32'h8000_0000, 0);
        send(OP_LIT, '1, 0);
        send(OP_DIV, 0, 0);                  // quotient overflow
        send(OP_LIT, 0, 0);
        send(OP_DIV, 0, 0);                  // divide by zero
        send(OP_RED, 0, 32'h7fff_ffff);
        send(OP_LIT, -7, 0);
        send(OP_DIV, 0, 0);
        send(OP_MUL, 0, 0);
        send(OP_SUB, 0, 0);
        send(OP_ADD, 0, 0);
        send(OP_LOD, -1, 0);                 // out of range read
        send(OP_STO, 32'h7fff_ffff, 0);      // out of range write
        send(OP_CAL, 32'hffff_ffff, 0);
        send(OP_INT, 5, 0);
        send(OP_RET, 0, 0);
        send(OP_INT, 32'h7fff_ffff, 0);      // saturate high, full stack
        send(OP_LIT, 1, 0);                  // push on full stack
        send(OP_INT, 32'h8000_0000, 0);      // saturate low
        send(OP_LIT, 0, 0);
        send(OP_JPC, 4095, 0);
        send(OP_JMP, 4095, 0);               // jump to the last address; the next instruction wraps to halt
        send(4'd14, 0, 0);
        send(4'd15, 0, 0);
        for (int i = 0; i < 500; i++)
        begin
            if (i == 420) calm = 1;
            send_random();
        end
        valid_in <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0) $display("testbench: PASS");
        else $display("testbench: FAIL");
        $finish;
    end
endmodule

// ----- files.f -----
hdl/sme_pkg.sv
hdl/sme_divider.sv
hdl/stack_machine_executor.sv
tb/testbench.sv
